@@ rtl/core/ecl_pkg.sv @@
// shared payload types and token codes for the expression character lexer
package ecl_pkg;

    localparam logic [2:0] KIND_OP2 = 3'd0;
    localparam logic [2:0] KIND_OP1 = 3'd1;
    localparam logic [2:0] KIND_NUM = 3'd2;
    localparam logic [2:0] KIND_ID  = 3'd3;
    localparam logic [2:0] KIND_END = 3'd4;

    localparam logic [2:0] IDENT_MAX = 3'd7;

    typedef struct packed {
        logic [7:0] char_code;
        logic       char_valid;
        logic       end_of_text;
    } t_char_in;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [7:0]  op_first;
        logic [7:0]  op_second;
        logic [31:0] number_value;
        logic [55:0] ident_text;
        logic [2:0]  ident_length;
        logic [5:0]  token_position;
        logic        final_token;
    } t_token_out;

endpackage

@@ rtl/core/expression_char_lexer.sv @@
// expression character lexer: characters in, operator / number / identifier tokens out
//
// input channel (i_valid, o_ready, i_char) takes one character item per transfer;
// output channel (o_valid, i_ready, o_token) gives one token per transfer.
// an accepted item waits in the input register until it is scanned; the scan logic then
// updates the lexer state and pushes the 0 to 3 tokens it causes into an
// 8-entry result queue; the first token is offered on o_valid once it is written there.
// throughput is one character per cycle while the queue has room; the drain rate
// of the queue, one token per cycle, sets it when items yield more than one token.
// an item is scanned only while the queue has room for 3 tokens, so a
// stalled receiver fills the queue and then holds o_ready low; nothing is
// dropped. the item flagged end_of_text flushes the open token, adds the end
// token and returns the lexer to its reset state.
// reset (i_rst_n low, synchronous) empties the queue and the input register
// and clears the lexer state; o_ready is high in the first cycle after it.
module expression_char_lexer #(
    parameter int TOKEN_CAP = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  ecl_pkg::t_char_in     i_char,
    output logic                  o_valid,
    input  logic                  i_ready,
    output ecl_pkg::t_token_out   o_token
);
    import ecl_pkg::*;

    localparam int CNT_W = ($clog2(TOKEN_CAP) > 6) ? $clog2(TOKEN_CAP) : 6;
    localparam logic [CNT_W:0] LIMIT = (CNT_W + 1)'(TOKEN_CAP - 1);
    localparam int Q_DEPTH = 8;
    localparam int Q_AW = $clog2(Q_DEPTH);
    localparam logic [Q_AW:0] Q_ROOM = (Q_AW + 1)'(Q_DEPTH - 3);

    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_HELD  = 3'd1;
    localparam logic [2:0] MODE_DEC   = 3'd2;
    localparam logic [2:0] MODE_HEX   = 3'd3;
    localparam logic [2:0] MODE_IDENT = 3'd4;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DOLL  = 8'h24;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_UNDER = 8'h5F;
    localparam logic [7:0] CH_BAR   = 8'h7C;

    typedef struct packed {
        logic       emit;
        t_token_out tok;
    } t_close;

    function automatic t_token_out make_tok(
        input logic [2:0]  kind,
        input logic [7:0]  op1,
        input logic [7:0]  op2,
        input logic [31:0] num,
        input logic [55:0] txt,
        input logic [2:0]  len,
        input logic [5:0]  pos,
        input logic        fin
    );
        t_token_out t;
        t.token_kind     = kind;
        t.op_first       = op1;
        t.op_second      = op2;
        t.number_value   = num;
        t.ident_text     = txt;
        t.ident_length   = len;
        t.token_position = pos;
        t.final_token    = fin;
        return t;
    endfunction

    // token left open by the current scan mode, if any
    function automatic t_close close_tok(
        input logic [2:0]  mode,
        input logic [7:0]  held,
        input logic [31:0] acc,
        input logic [55:0] ibuf,
        input logic [2:0]  icnt,
        input logic [5:0]  pos
    );
        t_close r;
        r.emit = 1'b0;
        r.tok  = '0;
        if (mode == MODE_HELD && (held == CH_LT || held == CH_GT)) begin
            r.emit = 1'b1;
            r.tok  = make_tok(KIND_OP1, held, 8'd0, 32'd0, 56'd0, 3'd0, pos, 1'b0);
        end else if (mode == MODE_DEC || mode == MODE_HEX) begin
            r.emit = 1'b1;
            r.tok  = make_tok(KIND_NUM, 8'd0, 8'd0, acc, 56'd0, 3'd0, pos, 1'b0);
        end else if (mode == MODE_IDENT) begin
            r.emit = 1'b1;
            r.tok  = make_tok(KIND_ID, 8'd0, 8'd0, 32'd0, ibuf, icnt, pos, 1'b0);
        end
        return r;
    endfunction

    logic            r_in_valid;
    t_char_in        r_in;
    logic [2:0]      r_mode;
    logic [7:0]      r_held;
    logic [31:0]     r_acc;
    logic [55:0]     r_ibuf;
    logic [2:0]      r_icnt;
    logic [CNT_W-1:0] r_cnt;

    t_token_out      r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_qcnt;
    logic [Q_AW:0]   n_qcnt;

    logic            proc;
    logic            pop;
    logic            in_take;

    logic [2:0]      n_mode;
    logic [7:0]      n_held;
    logic [31:0]     n_acc;
    logic [55:0]     n_ibuf;
    logic [2:0]      n_icnt;
    logic [CNT_W-1:0] n_cnt;
    logic [1:0]      nres;
    t_token_out      res [3];
    t_close          cl;

    logic [7:0]      c;
    logic [7:0]      c_up;
    logic            is_d;
    logic            is_a;
    logic            is_hx;
    logic [3:0]      hx_val;
    logic            take;
    logic            fall;
    logic            do_close;
    logic            pair;

    assign proc    = r_in_valid && (r_qcnt <= Q_ROOM);
    assign o_ready = !r_in_valid || proc;
    assign in_take = i_valid && o_ready;
    assign o_valid = (r_qcnt != '0);
    assign pop     = o_valid && i_ready;
    assign o_token = r_q[r_rd];

    assign c      = r_in.char_code;
    assign c_up   = (c >= 8'h61 && c <= 8'h7A) ? (c & 8'hDF) : c;
    assign is_d   = (c >= 8'h30 && c <= 8'h39);
    assign is_a   = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    assign is_hx  = is_d || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
    // letters a-f / A-F have low nibble 1..6
    assign hx_val = is_d ? c[3:0] : (c[3:0] + 4'd9);
    assign pair   = (c == CH_EQ && (r_held == CH_EQ || r_held == CH_BANG ||
                                    r_held == CH_LT || r_held == CH_GT)) ||
                    (c == CH_AMP && r_held == CH_AMP) ||
                    (c == CH_BAR && r_held == CH_BAR);

    always_comb begin
        n_mode   = r_mode;
        n_held   = r_held;
        n_acc    = r_acc;
        n_ibuf   = r_ibuf;
        n_icnt   = r_icnt;
        n_cnt    = r_cnt;
        nres     = 2'd0;
        res[0]   = '0;
        res[1]   = '0;
        res[2]   = '0;
        fall     = 1'b0;
        do_close = 1'b0;
        cl       = '0;
        take     = r_in.char_valid && ({1'b0, r_cnt} < LIMIT);

        if (take) begin
            case (r_mode)
                MODE_HELD: begin
                    if (pair) begin
                        res[nres] = make_tok(KIND_OP2, r_held, c, 32'd0, 56'd0, 3'd0,
                                             n_cnt[5:0], 1'b0);
                        nres   = nres + 2'd1;
                        n_cnt  = n_cnt + CNT_W'(1);
                        n_mode = MODE_IDLE;
                        n_held = 8'd0;
                    end else begin
                        do_close = 1'b1;
                    end
                end
                MODE_DEC: begin
                    if (is_d) begin
                        n_acc = (r_acc << 3) + (r_acc << 1) + {28'd0, c[3:0]};
                    end else begin
                        do_close = 1'b1;
                    end
                end
                MODE_HEX: begin
                    if (is_hx) begin
                        n_acc = {r_acc[27:0], hx_val};
                    end else begin
                        do_close = 1'b1;
                    end
                end
                MODE_IDENT: begin
                    if (is_a || is_d || c == CH_UNDER) begin
                        if (r_icnt < IDENT_MAX) begin
                            n_ibuf = r_ibuf | ({48'd0, c_up} << {r_icnt, 3'b000});
                            n_icnt = r_icnt + 3'd1;
                        end
                    end else begin
                        do_close = 1'b1;
                    end
                end
                default: begin
                    fall = 1'b1;
                end
            endcase

            if (do_close) begin
                fall = 1'b1;
                cl = close_tok(n_mode, n_held, n_acc, n_ibuf, n_icnt, n_cnt[5:0]);
                if (cl.emit) begin
                    res[nres] = cl.tok;
                    nres  = nres + 2'd1;
                    n_cnt = n_cnt + CNT_W'(1);
                end
                n_mode = MODE_IDLE;
                n_held = 8'd0;
                n_acc  = 32'd0;
                n_ibuf = 56'd0;
                n_icnt = 3'd0;
            end

            // the terminating character (or one met while idle) starts a new token unless the limit was just hit
            if (fall && ({1'b0, n_cnt} < LIMIT)) begin
                if (c == CH_SPACE || c == CH_TAB) begin
                    n_mode = MODE_IDLE;
                end else if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT ||
                             c == CH_AMP || c == CH_BAR) begin
                    n_mode = MODE_HELD;
                    n_held = c;
                end else if (c == CH_LPAR || c == CH_RPAR || c == CH_PLUS ||
                             c == CH_MINUS || c == CH_STAR || c == CH_COMMA) begin
                    res[nres] = make_tok(KIND_OP1, c, 8'd0, 32'd0, 56'd0, 3'd0,
                                         n_cnt[5:0], 1'b0);
                    nres  = nres + 2'd1;
                    n_cnt = n_cnt + CNT_W'(1);
                end else if (c == CH_DOLL) begin
                    n_mode = MODE_HEX;
                    n_acc  = 32'd0;
                end else if (is_d) begin
                    n_mode = MODE_DEC;
                    n_acc  = {28'd0, c[3:0]};
                end else if (is_a || c == CH_UNDER) begin
                    n_mode = MODE_IDENT;
                    n_ibuf = {48'd0, c_up};
                    n_icnt = 3'd1;
                end
            end
        end

        if (r_in.end_of_text) begin
            cl = close_tok(n_mode, n_held, n_acc, n_ibuf, n_icnt, n_cnt[5:0]);
            if (cl.emit) begin
                res[nres] = cl.tok;
                nres  = nres + 2'd1;
                n_cnt = n_cnt + CNT_W'(1);
            end
            res[nres] = make_tok(KIND_END, 8'd0, 8'd0, 32'd0, 56'd0, 3'd0,
                                 n_cnt[5:0], 1'b1);
            nres   = nres + 2'd1;
            n_mode = MODE_IDLE;
            n_held = 8'd0;
            n_acc  = 32'd0;
            n_ibuf = 56'd0;
            n_icnt = 3'd0;
            n_cnt  = '0;
        end
    end

    assign n_qcnt = r_qcnt + (proc ? {{(Q_AW - 1){1'b0}}, nres} : '0)
                  - {{Q_AW{1'b0}}, pop};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_IDLE;
            r_held     <= 8'd0;
            r_acc      <= 32'd0;
            r_ibuf     <= 56'd0;
            r_icnt     <= 3'd0;
            r_cnt      <= '0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_qcnt     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (proc) begin
                r_mode <= n_mode;
                r_held <= n_held;
                r_acc  <= n_acc;
                r_ibuf <= n_ibuf;
                r_icnt <= n_icnt;
                r_cnt  <= n_cnt;
                r_wr   <= r_wr + Q_AW'(nres);
            end
            if (pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            r_qcnt <= n_qcnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_char;
        end
        for (int k = 0; k < 3; k++) begin
            if (proc && (k < int'(nres))) begin
                r_q[r_wr + Q_AW'(k)] <= res[k];
            end
        end
    end

endmodule
